// ----- rtl/fcs_pkg.sv -----
package fcs_pkg;

	localparam int unsigned ADDR_W = 22;
	localparam int unsigned STEP_W = 3;

	typedef enum logic [2:0] {
		CMD_PROGRAM = 3'd0,
		CMD_ERASE   = 3'd1,
		CMD_READ_ID = 3'd2,
		CMD_READ    = 3'd3,
		CMD_WRITE   = 3'd4,
		CMD_POLL    = 3'd5
	} cmd_t;

	// Where the address of one bus access comes from.
	typedef enum logic [2:0] {
		SRC_UNLOCK1,
		SRC_UNLOCK2,
		SRC_TARGET,
		SRC_BASE,
		SRC_BASE1
	} addr_src_t;

	localparam logic [ADDR_W-1:0] BASE_MASK_RST = 22'h380000;
	localparam logic [ADDR_W-1:0] UNLOCK1_OFS   = 22'h005555;
	localparam logic [ADDR_W-1:0] UNLOCK2_OFS   = 22'h002AAA;
	localparam logic [ADDR_W-1:0] ID_NEXT_OFS   = 22'h000001;

	localparam logic [7:0] BYTE_UNLOCK1  = 8'hAA;
	localparam logic [7:0] BYTE_UNLOCK2  = 8'h55;
	localparam logic [7:0] BYTE_PROGRAM  = 8'hA0;
	localparam logic [7:0] BYTE_ERASE    = 8'h80;
	localparam logic [7:0] BYTE_SECTOR   = 8'h30;
	localparam logic [7:0] BYTE_ID_ENTRY = 8'h90;
	localparam logic [7:0] BYTE_ID_EXIT  = 8'hF0;
	localparam logic [7:0] TOGGLE_BIT    = 8'h40;

	typedef struct packed {
		logic        is_write;
		logic [7:0]  bank;
		logic [15:0] window_pointer;
		logic [7:0]  bus_byte;
		logic        poll_done;
		logic        last;
	} result_t;

	// The latched command word and the precomputed values the step logic needs.
	typedef struct packed {
		cmd_t              cmd;
		logic [ADDR_W-1:0] addr;
		logic [ADDR_W-1:0] base;
		logic [7:0]        data;
		logic              done;
	} cmd_word_t;

endpackage

// ----- rtl/fcs_step_gen.sv -----
module fcs_step_gen
	import fcs_pkg::*;
(
	input  cmd_word_t         word,
	input  logic [STEP_W-1:0] step,
	output result_t           res
);

	logic [ADDR_W-1:0] unlock1_addr;
	logic [ADDR_W-1:0] unlock2_addr;
	logic [ADDR_W-1:0] base1_addr;
	logic [ADDR_W-1:0] sel_addr;
	addr_src_t         src;
	logic              wr;
	logic [7:0]        bus_byte;
	logic              last;
	logic              done;

	// Offsets wrap modulo the 22-bit address space.
	assign unlock1_addr = word.base + UNLOCK1_OFS;
	assign unlock2_addr = word.base + UNLOCK2_OFS;
	assign base1_addr   = word.base + ID_NEXT_OFS;

	always_comb begin
		src      = SRC_TARGET;
		wr       = 1'b1;
		bus_byte = 8'h00;
		last     = 1'b0;
		done     = 1'b0;
		case (word.cmd)
			CMD_PROGRAM: begin
				case (step)
					3'd0: begin src = SRC_UNLOCK1; bus_byte = BYTE_UNLOCK1; end
					3'd1: begin src = SRC_UNLOCK2; bus_byte = BYTE_UNLOCK2; end
					3'd2: begin src = SRC_UNLOCK1; bus_byte = BYTE_PROGRAM; end
					default: begin bus_byte = word.data; last = 1'b1; end
				endcase
			end
			CMD_ERASE: begin
				case (step)
					3'd0, 3'd3: begin src = SRC_UNLOCK1; bus_byte = BYTE_UNLOCK1; end
					3'd1, 3'd4: begin src = SRC_UNLOCK2; bus_byte = BYTE_UNLOCK2; end
					3'd2: begin src = SRC_UNLOCK1; bus_byte = BYTE_ERASE; end
					default: begin bus_byte = BYTE_SECTOR; last = 1'b1; end
				endcase
			end
			CMD_READ_ID: begin
				case (step)
					3'd0, 3'd5: begin src = SRC_UNLOCK1; bus_byte = BYTE_UNLOCK1; end
					3'd1, 3'd6: begin src = SRC_UNLOCK2; bus_byte = BYTE_UNLOCK2; end
					3'd2: begin src = SRC_UNLOCK1; bus_byte = BYTE_ID_ENTRY; end
					3'd3: begin src = SRC_BASE; wr = 1'b0; end
					3'd4: begin src = SRC_BASE1; wr = 1'b0; end
					default: begin
						src = SRC_UNLOCK1; bus_byte = BYTE_ID_EXIT; last = 1'b1;
					end
				endcase
			end
			CMD_WRITE: begin
				bus_byte = word.data;
				last     = 1'b1;
			end
			CMD_POLL: begin
				wr   = 1'b0;
				done = word.done;
				last = 1'b1;
			end
			default: begin
				wr   = 1'b0;
				last = 1'b1;
			end
		endcase
	end

	always_comb begin
		case (src)
			SRC_UNLOCK1: sel_addr = unlock1_addr;
			SRC_UNLOCK2: sel_addr = unlock2_addr;
			SRC_BASE:    sel_addr = word.base;
			SRC_BASE1:   sel_addr = base1_addr;
			default:     sel_addr = word.addr;
		endcase
	end

	always_comb begin
		res.is_write       = wr;
		res.bank           = sel_addr[21:14];
		res.window_pointer = {2'b11, sel_addr[13:0]};
		res.bus_byte       = bus_byte;
		res.poll_done      = done;
		res.last           = last;
	end

endmodule

// ----- rtl/flash_command_sequencer.sv -----
// Flash command sequencer. Each command word accepted on start (while busy is
// low) expands into the bus accesses a parallel flash expects: program gives
// four, sector erase six, read ID eight, and read, write and poll one each.
// Commands six and seven are dropped and give nothing. Every access appears on
// the result ports for exactly one cycle with result_valid high; the receiver
// cannot stall, so it must take each word in the cycle it is shown. A step
// counter walks the latched command, one access per clock. Busy is high while
// a command still has accesses after the current one and drops in the cycle
// the final access is being formed, so the next command is taken in that same
// cycle and commands follow one another with no gap. Each access is formed
// from the latched command word and step counter, then registered onto the
// result ports. The chip base is the target address ANDed with the base mask
// (reset 0x380000), written through cfg_wr_en and cfg_wr_data; the user must
// write it only while the sequencer is idle; the block itself does not enforce it.
module flash_command_sequencer
	import fcs_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	output logic              busy,
	input  logic [2:0]        cmd,
	input  logic [ADDR_W-1:0] flash_address,
	input  logic [7:0]        write_byte,
	input  logic [7:0]        first_read,
	input  logic [7:0]        second_read,
	input  logic              cfg_wr_en,
	input  logic [ADDR_W-1:0] cfg_wr_data,
	output logic              result_valid,
	output logic              is_write,
	output logic [7:0]        bank,
	output logic [15:0]       window_pointer,
	output logic [7:0]        bus_byte,
	output logic              poll_done,
	output logic              last
);

	logic [ADDR_W-1:0] base_mask_q;
	logic              active_q;
	logic [STEP_W-1:0] step_q;
	cmd_word_t         word_q;
	logic              valid_q;
	result_t           res_q;
	result_t           cur_res;
	logic              accept;
	logic              cmd_known;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			base_mask_q <= BASE_MASK_RST;
		end else if (cfg_wr_en) begin
			base_mask_q <= cfg_wr_data;
		end
	end

	always_comb begin
		cmd_known = cmd inside {[CMD_PROGRAM:CMD_POLL]};
	end

	// The current step's access is formed from the latched word.
	fcs_step_gen u_step_gen (
		.word (word_q),
		.step (step_q),
		.res  (cur_res)
	);

	assign busy   = active_q && !cur_res.last;
	assign accept = start && !busy;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q <= 1'b0;
			step_q   <= '0;
		end else if (accept) begin
			active_q <= cmd_known;
			step_q   <= '0;
		end else if (active_q) begin
			if (cur_res.last) begin
				active_q <= 1'b0;
			end else begin
				step_q <= step_q + 1'b1;
			end
		end
	end

	// Latched command word; the chip base and poll verdict are settled here.
	always_ff @(posedge clk) begin
		if (accept) begin
			word_q.cmd  <= cmd_t'(cmd);
			word_q.addr <= flash_address;
			word_q.base <= flash_address & base_mask_q;
			word_q.data <= write_byte;
			word_q.done <= ((first_read ^ second_read) & TOGGLE_BIT) == 8'h00;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else begin
			valid_q <= active_q;
		end
	end

	always_ff @(posedge clk) begin
		if (active_q) begin
			res_q <= cur_res;
		end
	end

	assign result_valid   = valid_q;
	assign is_write       = res_q.is_write;
	assign bank           = res_q.bank;
	assign window_pointer = res_q.window_pointer;
	assign bus_byte       = res_q.bus_byte;
	assign poll_done      = res_q.poll_done;
	assign last           = res_q.last;

	// An accepted known command always produces its first access on the result ports.
	assert property (@(posedge clk) disable iff (!arst_n)
		accept && cmd_known |=> ##1 result_valid)
		else $error("accepted command produced no access");

	// Once the final access is formed with nothing new taken, output goes quiet.
	assert property (@(posedge clk) disable iff (!arst_n)
		active_q && cur_res.last && !start |=> ##1 !result_valid)
		else $error("access emitted after the end of a run");

	// Every run begins at its first step.
	assert property (@(posedge clk) disable iff (!arst_n)
		$rose(active_q) |-> step_q == '0)
		else $error("run started at a nonzero step");

	// A poll verdict only comes on a single read-type access.
	assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && poll_done |-> !is_write && last)
		else $error("poll verdict on a write or mid-run access");

endmodule
